// ----- rtl/tiu_pkg.sv -----
// tiu_pkg: shared types and sizes for the trie insert and lookup unit
// no dependencies
`default_nettype none
package tiu_pkg;

    localparam int NODES = 1024;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] symbol;
        logic       last;
    } item_t;

    typedef struct packed {
        logic found;
        logic status;
    } result_t;

    typedef struct packed {
        logic accept;
        logic rd_node;
        logic hit;
        logic step;
        logic alloc;
        logic fail;
        logic mark_end;
        logic rd_end;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic failed;
        logic cmd;
        logic last;
        logic scan_end;
        logic match;
        logic full;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

// ----- rtl/tiu_datapath.sv -----
// tiu_datapath: node store, cursor, scan index and result register
// depends on tiu_pkg
`default_nettype none
module tiu_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tiu_pkg::item_t  item,
    input  wire tiu_pkg::ctrl_t  ctrl,
    output tiu_pkg::stat_t       stat,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output tiu_pkg::result_t     result
);

    localparam int EW = tiu_pkg::IDX_W + 8;

    logic [EW-1:0]              node_mem [tiu_pkg::NODES];
    logic                       end_mem  [tiu_pkg::NODES];
    logic [EW-1:0]              rd_q_reg;
    logic                       end_q_reg;
    tiu_pkg::item_t             item_reg;
    logic [tiu_pkg::CNT_W-1:0]  count_reg;
    logic [tiu_pkg::CNT_W-1:0]  idx_reg;
    logic [tiu_pkg::IDX_W-1:0]  cursor_reg;
    logic                       failed_reg;
    logic                       out_valid_reg;
    tiu_pkg::result_t           out_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_node)
        begin
            rd_q_reg <= node_mem[idx_reg[tiu_pkg::IDX_W-1:0]];
        end
        if (ctrl.alloc)
        begin
            node_mem[count_reg[tiu_pkg::IDX_W-1:0]] <= {cursor_reg, item_reg.symbol};
        end
        if (ctrl.rd_end)
        begin
            end_q_reg <= end_mem[cursor_reg];
        end
        if (ctrl.alloc)
        begin
            end_mem[count_reg[tiu_pkg::IDX_W-1:0]] <= 1'b0;
        end
        else if (ctrl.mark_end)
        begin
            end_mem[cursor_reg] <= 1'b1;
        end
        if (ctrl.accept)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= tiu_pkg::CNT_W'(1);
            idx_reg       <= tiu_pkg::CNT_W'(1);
            cursor_reg    <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                idx_reg <= tiu_pkg::CNT_W'(1);
            end
            else if (ctrl.step)
            begin
                idx_reg <= idx_reg + tiu_pkg::CNT_W'(1);
            end
            if (ctrl.hit)
            begin
                cursor_reg <= idx_reg[tiu_pkg::IDX_W-1:0];
            end
            if (ctrl.alloc)
            begin
                cursor_reg <= count_reg[tiu_pkg::IDX_W-1:0];
                count_reg  <= count_reg + tiu_pkg::CNT_W'(1);
            end
            if (ctrl.fail)
            begin
                failed_reg <= 1'b1;
            end
            if (ctrl.emit)
            begin
                out_valid_reg  <= 1'b1;
                out_reg.found  <= (item_reg.cmd == tiu_pkg::CMD_LOOKUP) && !failed_reg
                                  && end_q_reg;
                out_reg.status <= (item_reg.cmd == tiu_pkg::CMD_INSERT) && failed_reg;
                cursor_reg     <= '0;
                failed_reg     <= 1'b0;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.failed   = failed_reg;
        stat.cmd      = item_reg.cmd;
        stat.last     = item_reg.last;
        stat.scan_end = idx_reg >= count_reg;
        stat.match    = (rd_q_reg[EW-1:8] == cursor_reg) && (rd_q_reg[7:0] == item_reg.symbol);
        stat.full     = count_reg == tiu_pkg::CNT_W'(tiu_pkg::NODES);
        stat.out_busy = out_valid_reg && !result_ready;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ----- rtl/tiu_ctrl.sv -----
// tiu_ctrl: sequencer for the per-byte edge search and key completion
// depends on tiu_pkg
`default_nettype none
module tiu_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire tiu_pkg::stat_t  stat,
    output tiu_pkg::ctrl_t       ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_CMP,
        S_MISS,
        S_FINISH,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        item_ready = state_reg == S_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (stat.failed)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.scan_end)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctrl.rd_node = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    ctrl.hit   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.step  = 1'b1;
                    state_next = S_START;
                end
            end
            S_MISS:
            begin
                if (stat.cmd == tiu_pkg::CMD_INSERT && !stat.full)
                begin
                    ctrl.alloc = 1'b1;
                end
                else
                begin
                    ctrl.fail = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (stat.cmd == tiu_pkg::CMD_INSERT)
                    begin
                        ctrl.mark_end = !stat.failed;
                    end
                    else
                    begin
                        ctrl.rd_end = 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/trie_insert_and_lookup_unit.sv -----
// trie_insert_and_lookup_unit: top level, sequencer plus node store datapath
// depends on tiu_pkg, tiu_ctrl, tiu_datapath
`default_nettype none
// Keys enter one byte per beat, cmd 0 inserting and cmd 1 looking up, last set on
// the final byte; that byte yields one result beat (found for lookup, status 1 when
// the node store filled during insert). Each byte scans the allocated nodes one
// entry at a time through the single node store read port, stopping at the entry
// that holds its edge, and no new byte is accepted until the last one is done; a
// final byte may also wait for the result port. A byte of a key that already
// missed or overflowed skips the scan.
module trie_insert_and_lookup_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire tiu_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output tiu_pkg::result_t     result
);

    tiu_pkg::ctrl_t ctrl;
    tiu_pkg::stat_t stat;

    tiu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    tiu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking testbench for trie_insert_and_lookup_unit, keys sent byte by byte
// and every result compared with an internal trie predictor
// depends on tiu_pkg and the rtl top level
`default_nettype none
module tb;

    localparam int STALL_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    tiu_pkg::item_t item;
    logic result_valid;
    logic result_ready;
    tiu_pkg::result_t result;

    trie_insert_and_lookup_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    // predictor state
    logic [tiu_pkg::IDX_W-1:0] trie_parent [tiu_pkg::NODES];
    logic [7:0]                trie_symbol [tiu_pkg::NODES];
    logic                      trie_end [tiu_pkg::NODES];
    int                        trie_count;
    int                        trie_cursor;
    bit                        trie_failed;

    tiu_pkg::result_t expected_results [$];
    int  failures;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  idle_count;
    bit  send_done;

    // a small pool of keys so lookups hit and prefixes get shared
    logic [7:0] key_pool [32][8];
    int         key_len [32];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void trie_step(input tiu_pkg::item_t b);
        int child;
        tiu_pkg::result_t r;
        child = 0;
        if (!trie_failed)
        begin
            for (int i = 1; i < trie_count; i++)
                if (trie_parent[i] == trie_cursor && trie_symbol[i] == b.symbol && child == 0)
                    child = i;
            if (child != 0)
                trie_cursor = child;
            else if (b.cmd == tiu_pkg::CMD_INSERT && trie_count < tiu_pkg::NODES)
            begin
                trie_parent[trie_count] = trie_cursor[tiu_pkg::IDX_W-1:0];
                trie_symbol[trie_count] = b.symbol;
                trie_end[trie_count] = 1'b0;
                trie_cursor = trie_count;
                trie_count++;
            end
            else
                trie_failed = 1'b1;
        end
        if (b.last)
        begin
            r = '0;
            if (b.cmd == tiu_pkg::CMD_INSERT)
            begin
                if (!trie_failed)
                    trie_end[trie_cursor] = 1'b1;
                r.status = trie_failed;
            end
            else
                r.found = !trie_failed && trie_end[trie_cursor];
            expected_results.push_back(r);
            trie_cursor = 0;
            trie_failed = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic cmd, input logic [7:0] sym, input logic last);
        tiu_pkg::item_t b;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        b.cmd = cmd;
        b.symbol = sym;
        b.last = last;
        item_valid <= 1'b1;
        item <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        trie_step(b);
    endtask

    task automatic send_key(input logic cmd, input int k);
        for (int i = 0; i < key_len[k]; i++)
            send_byte(cmd, key_pool[k][i], i == key_len[k] - 1);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat found=%0d status=%0d",
                    result.found, result.status);
                failures++;
            end
            else
            begin
                tiu_pkg::result_t e;
                e = expected_results.pop_front();
                if (e.found !== result.found)
                begin
                    $error("found: expected %0d actual %0d", e.found, result.found);
                    failures++;
                end
                if (e.status !== result.status)
                begin
                    $error("status: expected %0d actual %0d", e.status, result.status);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n
            || (send_done && expected_results.size() == 0))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        // extremes of symbol, single byte keys, shared prefix, key ending on existing node
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h00, 1'b1);
        send_byte(tiu_pkg::CMD_INSERT, 8'h00, 1'b1);
        send_byte(tiu_pkg::CMD_INSERT, 8'hff, 1'b1);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h00, 1'b1);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'hff, 1'b1);
        send_byte(tiu_pkg::CMD_INSERT, 8'h41, 1'b0);
        send_byte(tiu_pkg::CMD_INSERT, 8'h42, 1'b0);
        send_byte(tiu_pkg::CMD_INSERT, 8'h43, 1'b1);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h41, 1'b0);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h42, 1'b1);
        send_byte(tiu_pkg::CMD_INSERT, 8'h41, 1'b0);
        send_byte(tiu_pkg::CMD_INSERT, 8'h42, 1'b1);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h41, 1'b0);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h42, 1'b1);
        // lookup miss then mixed commands
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h55, 1'b0);
        send_byte(tiu_pkg::CMD_INSERT, 8'h66, 1'b1);
        send_byte(tiu_pkg::CMD_INSERT, 8'h77, 1'b0);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'haa, 1'b1);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'h77, 1'b1);
        drain();
    endtask

    task automatic test_random(input int n);
        int sent;
        int k;
        sent = 0;
        while (sent < n)
        begin
            k = $urandom_range(31);
            if ($urandom_range(9) < 8)
            begin
                send_key($urandom_range(2) == 0 ? tiu_pkg::CMD_INSERT : tiu_pkg::CMD_LOOKUP, k);
                sent += key_len[k];
            end
            else
            begin
                send_byte(1'($urandom_range(1)), 8'($urandom_range(255)),
                    $urandom_range(3) == 0);
                sent++;
            end
            if ($urandom_range(60) == 0)
                drain();
        end
        // finish any open key
        send_byte(tiu_pkg::CMD_LOOKUP, 8'($urandom_range(255)), 1'b1);
        drain();
    endtask

    task automatic test_store_full();
        // long random insert keys until the store overflows
        while (trie_count < tiu_pkg::NODES)
        begin
            for (int i = 0; i < 7; i++)
                send_byte(tiu_pkg::CMD_INSERT, 8'($urandom_range(255)), i == 6);
        end
        send_byte(tiu_pkg::CMD_INSERT, 8'h12, 1'b0);
        send_byte(tiu_pkg::CMD_INSERT, 8'h34, 1'b1);
        send_byte(tiu_pkg::CMD_INSERT, 8'h00, 1'b1);
        send_byte(tiu_pkg::CMD_LOOKUP, 8'hff, 1'b1);
        send_key(tiu_pkg::CMD_INSERT, 0);
        send_key(tiu_pkg::CMD_LOOKUP, 0);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        failures = 0;
        send_done = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 83;
        trie_count = 1;
        trie_cursor = 0;
        trie_failed = 1'b0;
        for (int i = 0; i < tiu_pkg::NODES; i++)
            trie_end[i] = 1'b0;
        for (int k = 0; k < 32; k++)
        begin
            key_len[k] = $urandom_range(8, 1);
            for (int i = 0; i < 8; i++)
                key_pool[k][i] = (k < 16) ? 8'($urandom_range(255))
                                          : 8'(8'h30 + $urandom_range(3));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250);
        send_idle_pct = 83;
        recv_idle_pct = 7;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        test_store_full();

        send_done = 1'b1;
        repeat (50) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- trie_insert_and_lookup_unit.f -----
rtl/tiu_pkg.sv
rtl/tiu_datapath.sv
rtl/tiu_ctrl.sv
rtl/trie_insert_and_lookup_unit.sv
sim/tb.sv
